[design/mask_rect_area_and_cut_assert.svh]
// assertion macros used by the checker file
// each macro expects clk and rst_n in scope
`ifndef MASK_RECT_AREA_AND_CUT_ASSERT_SVH
`define MASK_RECT_AREA_AND_CUT_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define MRAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define MRAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[design/mrac_pkg.sv]
package mrac_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int AREA_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 9'd256;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CUT   = 2'd2;

  typedef struct packed {
    logic capture;
    logic load_rd;
    logic load_wr;
    logic issue;
    logic scan;
    logic row_init;
    logic set_flag;
    logic clr_wr;
    logic out_load;
  } mrac_cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic clr_last;
    logic rows_done;
    logic pipe_busy;
    logic over_limit;
  } mrac_status_t;

  // bit count of a 16 bit slice, pairwise adds
  function automatic logic [4:0] pop16(input logic [15:0] v);
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    a = v - ((v >> 1) & 16'h5555);
    b = (a & 16'h3333) + ((a >> 2) & 16'h3333);
    c = (b + (b >> 4)) & 16'h0F0F;
    return 5'(c[7:0] + c[15:8]);
  endfunction

endpackage

[design/mask_rect_area_and_cut.sv]
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | operation, pos_x, pos_y, rect_w, rect_h,
//         |           |                      | pixel_set, area_limit
// out     | output    | out_valid / out_ready| rect_area, remaining_area, below_limit
// cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
// one word at a time: a load reads and rewrites one row, a cut scans the rows the clipped
// rectangle covers, and a query sums their counts first and scans them only when over the
// limit; the mask memory read port visits one row per cycle
// reset and every size write run a clearing pass over every mask row, in_ready low
// a finished word waits in the output register; the next word is taken meanwhile
// and holds in its last cycle until the output register is free
module mask_rect_area_and_cut import mrac_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_operation,
  input  logic [7:0]            in_pos_x,
  input  logic [7:0]            in_pos_y,
  input  logic [8:0]            in_rect_w,
  input  logic [8:0]            in_rect_h,
  input  logic                  in_pixel_set,
  input  logic [AREA_W-1:0]     in_area_limit,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [AREA_W-1:0]     out_rect_area,
  output logic [AREA_W-1:0]     out_remaining_area,
  output logic                  out_below_limit,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  mrac_cmd_t    cmd;
  mrac_status_t status;

  mrac_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .cmd          (cmd)
  );

  mrac_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_operation       (in_operation),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_rect_w          (in_rect_w),
    .in_rect_h          (in_rect_h),
    .in_pixel_set       (in_pixel_set),
    .in_area_limit      (in_area_limit),
    .cmd                (cmd),
    .status             (status),
    .out_rect_area      (out_rect_area),
    .out_remaining_area (out_remaining_area),
    .out_below_limit    (out_below_limit)
  );

endmodule

[design/mrac_ram.sv]
module mrac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/mrac_ctrl.sv]
module mrac_ctrl import mrac_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   in_operation,
  output logic         out_valid,
  input  logic         out_ready,
  input  mrac_status_t status,
  output mrac_cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_CLEAR      = 9'b000000001,
    ST_IDLE       = 9'b000000010,
    ST_LOAD_RD    = 9'b000000100,
    ST_LOAD_WR    = 9'b000001000,
    ST_SUM        = 9'b000010000,
    ST_SUM_DRAIN  = 9'b000100000,
    ST_SCAN       = 9'b001000000,
    ST_SCAN_DRAIN = 9'b010000000,
    ST_DONE       = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_operation)
            OP_LOAD:  state_nxt = ST_LOAD_RD;
            OP_QUERY: state_nxt = ST_SUM;
            OP_CUT:   state_nxt = ST_SCAN;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_LOAD_RD: begin
        cmd.load_rd = 1'b1;
        state_nxt   = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        cmd.load_wr = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_SUM: begin
        if (!status.rows_done) begin
          cmd.issue = 1'b1;
        end else begin
          state_nxt = ST_SUM_DRAIN;
        end
      end
      ST_SUM_DRAIN: begin
        if (!status.pipe_busy) begin
          if (status.over_limit) begin
            cmd.row_init = 1'b1;
            state_nxt    = ST_SCAN;
          end else begin
            cmd.set_flag = 1'b1;
            state_nxt    = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (!status.rows_done) begin
          cmd.issue = 1'b1;
        end else begin
          state_nxt = ST_SCAN_DRAIN;
        end
      end
      ST_SCAN_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
    // a size write wipes the image
    if (status.cfg_hit) begin
      state_nxt = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[design/mrac_dp.sv]
module mrac_dp import mrac_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [1:0]            in_operation,
  input  logic [7:0]            in_pos_x,
  input  logic [7:0]            in_pos_y,
  input  logic [8:0]            in_rect_w,
  input  logic [8:0]            in_rect_h,
  input  logic                  in_pixel_set,
  input  logic [AREA_W-1:0]     in_area_limit,
  input  mrac_cmd_t             cmd,
  output mrac_status_t          status,
  output logic [AREA_W-1:0]     out_rect_area,
  output logic [AREA_W-1:0]     out_remaining_area,
  output logic                  out_below_limit
);

  localparam int RA    = $clog2(MAX_HEIGHT);
  localparam int CNTW  = $clog2(MAX_WIDTH + 1);
  localparam int XW0   = $clog2(MAX_WIDTH + 1);
  localparam int YW0   = $clog2(MAX_HEIGHT + 1);
  localparam int XW    = (XW0 > 10) ? XW0 : 10;
  localparam int YW    = (YW0 > 10) ? YW0 : 10;
  localparam int TW0   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int TW    = (TW0 > AREA_W) ? TW0 : AREA_W;
  localparam int NG    = (MAX_WIDTH + 63) / 64;
  localparam int NCH   = NG * 4;
  localparam int PADW  = NCH * 16;

  // size registers
  logic [CFG_DATA_W-1:0] img_w_r, img_h_r;
  logic                  cfg_hit;

  assign cfg_hit = cfg_we &&
                   (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= SIZE_RESET;
      img_h_r <= SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IMAGE_WIDTH) begin
        img_w_r <= cfg_wdata;
      end
      if (cfg_index == CFG_IMAGE_HEIGHT) begin
        img_h_r <= cfg_wdata;
      end
    end
  end

  logic [XW-1:0] eff_w, x_end, x1;
  logic [YW-1:0] eff_h, y_end, y1;

  assign eff_w = (XW'(img_w_r) > XW'(MAX_WIDTH))  ? XW'(MAX_WIDTH)  : XW'(img_w_r);
  assign eff_h = (YW'(img_h_r) > YW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(img_h_r);
  assign x_end = XW'(in_pos_x) + XW'(in_rect_w);
  assign y_end = YW'(in_pos_y) + YW'(in_rect_h);
  assign x1    = (x_end > eff_w) ? eff_w : x_end;
  assign y1    = (y_end > eff_h) ? eff_h : y_end;

  logic [MAX_WIDTH-1:0] colmask_nxt;

  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      if (in_operation == OP_LOAD) begin
        colmask_nxt[c] = (XW'(c) == XW'(in_pos_x));
      end else begin
        colmask_nxt[c] = (XW'(c) >= XW'(in_pos_x)) && (XW'(c) < x1);
      end
    end
  end

  // item registers
  logic [MAX_WIDTH-1:0] colmask_r;
  logic [YW-1:0]        y1_r, py_r, row_r;
  logic                 pset_r, cut_r, load_ok_r;
  logic [AREA_W-1:0]    limit_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      colmask_r <= colmask_nxt;
      y1_r      <= y1;
      py_r      <= YW'(in_pos_y);
      pset_r    <= in_pixel_set;
      cut_r     <= (in_operation == OP_CUT);
      load_ok_r <= (XW'(in_pos_x) < eff_w) && (YW'(in_pos_y) < eff_h);
      limit_r   <= in_area_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r <= YW'(in_pos_y);
    end else if (cmd.row_init) begin
      row_r <= py_r;
    end else if (cmd.issue) begin
      row_r <= row_r + YW'(1);
    end
  end

  // memories
  logic [MAX_WIDTH-1:0] mask_q, mask_wdata;
  logic [CNTW-1:0]      cnt_q, cnt_wdata;
  logic [RA-1:0]        mask_waddr, cnt_waddr, clr_r;
  logic                 mask_we, cnt_we, rd_en;

  assign rd_en = cmd.issue || cmd.load_rd;

  mrac_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mask_waddr),
    .wdata (mask_wdata),
    .re    (rd_en),
    .raddr (row_r[RA-1:0]),
    .rdata (mask_q)
  );

  mrac_ram #(.WIDTH(CNTW), .DEPTH(MAX_HEIGHT)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (rd_en),
    .raddr (row_r[RA-1:0]),
    .rdata (cnt_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cfg_hit) begin
      clr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_r <= clr_r + RA'(1);
    end
  end

  // scan pipeline: read, mask, slice counts, group sums, apply
  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic                 s1_scan_r;
  logic [RA-1:0]        s1_row_r, s2_row_r, s3_row_r, s4_row_r;
  logic [MAX_WIDTH-1:0] s2_bits_r;
  logic [CNTW-1:0]      s2_cnt_r, s3_cnt_r, s4_cnt_r;
  logic [4:0]           s3_chunk_r [NCH];
  logic [6:0]           s4_grp_r [NG];
  logic [6:0]           grp_nxt [NG];
  logic [PADW-1:0]      pad;
  logic [CNTW-1:0]      psum;

  assign pad = PADW'(s2_bits_r);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < 4; k++) begin
        grp_nxt[g] = grp_nxt[g] + 7'(s3_chunk_r[g * 4 + k]);
      end
    end
  end

  always_comb begin
    psum = '0;
    for (int g = 0; g < NG; g++) begin
      psum = psum + CNTW'(s4_grp_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r && s1_scan_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_scan_r <= cmd.scan;
    s1_row_r  <= row_r[RA-1:0];
    s2_bits_r <= mask_q & colmask_r;
    s2_cnt_r  <= cnt_q;
    s2_row_r  <= s1_row_r;
    for (int k = 0; k < NCH; k++) begin
      s3_chunk_r[k] <= pop16(pad[k*16 +: 16]);
    end
    s3_cnt_r <= s2_cnt_r;
    s3_row_r <= s2_row_r;
    for (int g = 0; g < NG; g++) begin
      s4_grp_r[g] <= grp_nxt[g];
    end
    s4_cnt_r <= s3_cnt_r;
    s4_row_r <= s3_row_r;
  end

  // single pixel load
  logic                 load_old, load_change;
  logic [MAX_WIDTH-1:0] load_row;
  logic [CNTW-1:0]      load_cnt;

  assign load_old    = |(mask_q & colmask_r);
  assign load_change = load_ok_r && (load_old != pset_r);
  assign load_row    = pset_r ? (mask_q | colmask_r) : (mask_q & ~colmask_r);
  assign load_cnt    = pset_r ? (cnt_q + CNTW'(1)) : (cnt_q - CNTW'(1));

  always_comb begin
    mask_we    = 1'b0;
    mask_waddr = s1_row_r;
    mask_wdata = mask_q & ~colmask_r;
    if (cmd.clr_wr) begin
      mask_we    = 1'b1;
      mask_waddr = clr_r;
      mask_wdata = '0;
    end else if (cmd.load_wr && load_change) begin
      mask_we    = 1'b1;
      mask_waddr = py_r[RA-1:0];
      mask_wdata = load_row;
    end else if (s1_v_r && s1_scan_r && cut_r) begin
      mask_we = 1'b1;
    end
  end

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = s4_row_r;
    cnt_wdata = s4_cnt_r - psum;
    if (cmd.clr_wr) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_r;
      cnt_wdata = '0;
    end else if (cmd.load_wr && load_change) begin
      cnt_we    = 1'b1;
      cnt_waddr = py_r[RA-1:0];
      cnt_wdata = load_cnt;
    end else if (s4_v_r && cut_r) begin
      cnt_we = 1'b1;
    end
  end

  // accumulators
  logic [TW-1:0] total_r, raw_r, area_r;
  logic          flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cfg_hit) begin
      total_r <= '0;
    end else if (cmd.load_wr && load_change) begin
      total_r <= pset_r ? (total_r + TW'(1)) : (total_r - TW'(1));
    end else if (s4_v_r && cut_r) begin
      total_r <= total_r - TW'(psum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_r  <= '0;
      area_r <= '0;
      flag_r <= 1'b0;
    end else begin
      if (s1_v_r && !s1_scan_r) begin
        raw_r <= raw_r + TW'(cnt_q);
      end
      if (s4_v_r) begin
        area_r <= area_r + TW'(psum);
      end
      if (cmd.set_flag) begin
        flag_r <= 1'b1;
      end
    end
  end

  // output word
  logic [AREA_W-1:0] out_area_r, out_remain_r;
  logic              out_flag_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_area_r   <= area_r[AREA_W-1:0];
      out_remain_r <= total_r[AREA_W-1:0];
      out_flag_r   <= flag_r;
    end
  end

  assign out_rect_area      = out_area_r;
  assign out_remaining_area = out_remain_r;
  assign out_below_limit    = out_flag_r;

  assign status.cfg_hit    = cfg_hit;
  assign status.clr_last   = (clr_r == RA'(MAX_HEIGHT - 1));
  assign status.rows_done  = (row_r >= y1_r);
  assign status.pipe_busy  = s1_v_r || s2_v_r || s3_v_r || s4_v_r;
  assign status.over_limit = (raw_r > TW'(limit_r));

endmodule

[design/mrac_checker.sv]
`include "mask_rect_area_and_cut_assert.svh"

module mrac_checker import mrac_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [AREA_W-1:0]    out_rect_area,
  input logic [AREA_W-1:0]    out_remaining_area,
  input logic                 out_below_limit,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index
);

  // a stalled result word holds
  `MRAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rect_area) && $stable(out_remaining_area) && $stable(out_below_limit), "result word changed while stalled")

  // only one word in flight
  `MRAC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input taken while busy")

  // a size write starts the clearing pass
  `MRAC_ASSERT_NEXT(a_cfg_clears, cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT), !in_ready, "input open during clearing pass")

  // a suppressed query reports no area
  `MRAC_ASSERT_NOW(a_flag_zero, out_valid && out_below_limit, out_rect_area == '0, "suppressed query with nonzero area")

endmodule

bind mask_rect_area_and_cut mrac_checker u_mrac_checker (.*);
